// File: hdl/ooke_pkg.sv
// ----------------------------------------------------------------------------
// ooke_pkg
// Types and constants shared by the OOK remote socket pulse encoder.
// ----------------------------------------------------------------------------
package ooke_pkg;

    localparam int DATA_WORD_W = 12;
    localparam int TICKS_W     = 16;
    localparam int REPEAT_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHORT_TICKS  = 2'd0,
        CFG_LONG_TICKS   = 2'd1,
        CFG_SYNC_TICKS   = 2'd2,
        CFG_REPEAT_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                   command;
        logic [DATA_WORD_W-1:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic done_res;
    } out_item_t;

    typedef struct packed {
        logic [TICKS_W-1:0] short_ticks;
        logic [TICKS_W-1:0] long_ticks;
        logic [TICKS_W-1:0] sync_ticks;
    } timing_cfg_t;

endpackage

// File: hdl/ooke_sequencer.sv
// ----------------------------------------------------------------------------
// ooke_sequencer
// Frame, bit and pulse sequencer with pulse duration counter; advances once
// per accepted request and presents the result for that request.
// ----------------------------------------------------------------------------
module ooke_sequencer #(
    parameter int DATAGRAM_BITS = 12,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  ooke_pkg::in_item_t                     item,
    input  ooke_pkg::timing_cfg_t                  timing,
    input  logic [ooke_pkg::REPEAT_W-1:0]          repeat_count,
    output ooke_pkg::out_item_t                    result
);
    import ooke_pkg::*;

    localparam int BIDX_W = $clog2(DATAGRAM_BITS + 1);
    localparam int LEN_W  = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
    localparam int EXT_W  = DATAGRAM_BITS + DATA_WORD_W;

    logic                     active_reg,  active_next;
    logic [DATAGRAM_BITS-1:0] shift_reg,   shift_next;
    logic [REPEAT_W-1:0]      repeat_reg,  repeat_next;
    logic [BIDX_W-1:0]        bit_reg,     bit_next;
    logic [1:0]               pulse_reg,   pulse_next;
    logic                     sync_reg,    sync_next;
    logic [COUNT_WIDTH-1:0]   elapsed_reg, elapsed_next;
    logic                     done;

    logic [TICKS_W-1:0]       raw_len;
    logic [LEN_W-1:0]         ext_len;
    logic [LEN_W-1:0]         cnt_max;
    logic [COUNT_WIDTH-1:0]   cur_len;
    logic [COUNT_WIDTH-1:0]   elapsed_inc;
    logic [EXT_W-1:0]         load_ext;
    logic [DATAGRAM_BITS-1:0] shift_rot;

    // pulse length for the current position
    always_comb
    begin
        if (sync_reg)
        begin
            raw_len = (pulse_reg == 2'd0) ? timing.short_ticks : timing.sync_ticks;
        end
        else
        begin
            case (pulse_reg)
                2'd0:    raw_len = timing.short_ticks;
                2'd1:    raw_len = timing.long_ticks;
                2'd2:    raw_len = shift_reg[0] ? timing.short_ticks : timing.long_ticks;
                default: raw_len = shift_reg[0] ? timing.long_ticks : timing.short_ticks;
            endcase
        end
    end

    assign ext_len = LEN_W'(raw_len);
    assign cnt_max = LEN_W'({COUNT_WIDTH{1'b1}});

    always_comb
    begin
        if (ext_len == '0)
        begin
            cur_len = COUNT_WIDTH'(1);
        end
        else if (ext_len > cnt_max)
        begin
            cur_len = cnt_max[COUNT_WIDTH-1:0];
        end
        else
        begin
            cur_len = ext_len[COUNT_WIDTH-1:0];
        end
    end

    assign elapsed_inc = elapsed_reg + COUNT_WIDTH'(1);
    assign load_ext    = EXT_W'(item.data_word);
    assign shift_rot   = (shift_reg >> 1) | (DATAGRAM_BITS'(shift_reg[0]) << (DATAGRAM_BITS - 1));

    always_comb
    begin
        active_next  = active_reg;
        shift_next   = shift_reg;
        repeat_next  = repeat_reg;
        bit_next     = bit_reg;
        pulse_next   = pulse_reg;
        sync_next    = sync_reg;
        elapsed_next = elapsed_reg;
        done         = 1'b0;

        if (item.command == CMD_START)
        begin
            if (!active_reg)
            begin
                active_next  = 1'b1;
                shift_next   = load_ext[DATAGRAM_BITS-1:0];
                repeat_next  = (repeat_count == '0) ? REPEAT_W'(1) : repeat_count;
                bit_next     = '0;
                pulse_next   = '0;
                sync_next    = 1'b0;
                elapsed_next = '0;
            end
        end
        else if (active_reg)
        begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= cur_len)
            begin
                elapsed_next = '0;
                if (sync_reg)
                begin
                    if (pulse_reg == 2'd0)
                    begin
                        pulse_next = 2'd1;
                    end
                    else
                    begin
                        pulse_next  = '0;
                        sync_next   = 1'b0;
                        repeat_next = repeat_reg - REPEAT_W'(1);
                        if (repeat_next == '0)
                        begin
                            active_next = 1'b0;
                            done        = 1'b1;
                        end
                    end
                end
                else if (pulse_reg != 2'd3)
                begin
                    pulse_next = pulse_reg + 2'd1;
                end
                else
                begin
                    pulse_next = '0;
                    shift_next = shift_rot;
                    if (bit_reg >= BIDX_W'(DATAGRAM_BITS - 1))
                    begin
                        bit_next  = '0;
                        sync_next = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg + BIDX_W'(1);
                    end
                end
            end
        end
    end

    assign result.line_level = active_next & ~pulse_next[0];
    assign result.busy_res   = active_next;
    assign result.done_res   = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            shift_reg   <= '0;
            repeat_reg  <= '0;
            bit_reg     <= '0;
            pulse_reg   <= '0;
            sync_reg    <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            active_reg  <= active_next;
            shift_reg   <= shift_next;
            repeat_reg  <= repeat_next;
            bit_reg     <= bit_next;
            pulse_reg   <= pulse_next;
            sync_reg    <= sync_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// File: hdl/ook_remote_socket_pulse_encoder.sv
// ----------------------------------------------------------------------------
// ook_remote_socket_pulse_encoder
// On-off keyed pulse-width encoder for a remote mains socket switch.
//
//   channel  signals                         direction  payload
//   in       in_valid / in_ready / in_data   input      command, data_word
//   out      out_valid / out_ready / out_data output    line_level, busy, done
//   cfg      cfg_valid / cfg_ready           input      cfg_index, cfg_data
//
// One request per cycle unless stalled; each result is registered on accept.
// The sequencer state and the result register update in the same cycle.
// A held result (out_ready low) stalls the input side only while full.
// Reset clears the sequencer and loads the default pulse timing and repeat count.
// ----------------------------------------------------------------------------
module ook_remote_socket_pulse_encoder #(
    parameter int DATAGRAM_BITS = 12,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ooke_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ooke_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ooke_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ooke_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ooke_pkg::*;

    timing_cfg_t         timing_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;
    out_item_t           step_result;
    logic                in_accept;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_accept = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ooke_sequencer #(
        .DATAGRAM_BITS (DATAGRAM_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_accept),
        .item         (in_data),
        .timing       (timing_reg),
        .repeat_count (repeat_count_reg),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.short_ticks <= TICKS_W'(300);
            timing_reg.long_ticks  <= TICKS_W'(900);
            timing_reg.sync_ticks  <= TICKS_W'(9000);
            repeat_count_reg       <= REPEAT_W'(6);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SHORT_TICKS:  timing_reg.short_ticks <= cfg_data;
                CFG_LONG_TICKS:   timing_reg.long_ticks  <= cfg_data;
                CFG_SYNC_TICKS:   timing_reg.sync_ticks  <= cfg_data;
                CFG_REPEAT_COUNT: repeat_count_reg       <= cfg_data[REPEAT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= step_result;
        end
    end

endmodule
